FILE: design/tcc_pkg.sv
// shared types and constants for the tetrahedron circumcenter pipeline
// no dependencies
package tcc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned IN_W           = 16;
  localparam int unsigned QW             = 32;

  localparam logic [QW-1:0] POS_LIMIT = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_LIMIT = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] p0_x;
    logic signed [IN_W-1:0] p0_y;
    logic signed [IN_W-1:0] p0_z;
    logic signed [IN_W-1:0] p1_x;
    logic signed [IN_W-1:0] p1_y;
    logic signed [IN_W-1:0] p1_z;
    logic signed [IN_W-1:0] p2_x;
    logic signed [IN_W-1:0] p2_y;
    logic signed [IN_W-1:0] p2_z;
    logic signed [IN_W-1:0] p3_x;
    logic signed [IN_W-1:0] p3_y;
    logic signed [IN_W-1:0] p3_z;
  } tcc_in_t;

  typedef struct packed {
    logic signed [QW-1:0] center_x;
    logic signed [QW-1:0] center_y;
    logic signed [QW-1:0] center_z;
    logic                 degenerate;
    logic                 saturated;
  } tcc_out_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic over;
  } tcc_flags_t;

endpackage

FILE: design/tcc_div_step.sv
// one registered restoring division step, one quotient bit
// depends on tcc_pkg
module tcc_div_step #(
  parameter int unsigned TW    = 78,
  parameter int unsigned DENW  = 70,
  parameter int unsigned SHIFT = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [TW-1:0]           rem_i,
  input  logic [DENW-1:0]         den_i,
  input  logic [tcc_pkg::QW-1:0]  quo_i,
  input  tcc_pkg::tcc_flags_t     flags_i,
  output logic                    valid_o,
  output logic [TW-1:0]           rem_o,
  output logic [DENW-1:0]         den_o,
  output logic [tcc_pkg::QW-1:0]  quo_o,
  output tcc_pkg::tcc_flags_t     flags_o
);
  import tcc_pkg::*;

  logic              ge;
  logic [TW-1:0]     den_ext;
  logic [TW-1:0]     rem_d, rem_q;
  logic [QW-1:0]     quo_d, quo_q;
  logic [DENW-1:0]   den_q;
  tcc_flags_t        flags_q;
  logic              valid_q;

  always_comb begin
    den_ext = TW'(den_i);
    ge      = (rem_i >> SHIFT) >= den_ext;
    rem_d   = ge ? (rem_i - (den_ext << SHIFT)) : rem_i;
    quo_d   = quo_i | (QW'(ge) << SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      den_q   <= den_i;
      quo_q   <= quo_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign flags_o = flags_q;

endmodule

FILE: design/tcc_quot.sv
// rounded, saturated quotient num / (2*d0) in signed fixed point
// depends on tcc_pkg and tcc_div_step
module tcc_quot #(
  parameter int unsigned COORD_BITS = tcc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF,
  localparam int unsigned DETW      = 4*COORD_BITS + 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [DETW-1:0] num_i,
  input  logic signed [DETW-1:0] d0_i,
  output logic                   valid_o,
  output logic [tcc_pkg::QW-1:0] value_o,
  output logic                   sat_o,
  output logic                   zero_o
);
  import tcc_pkg::*;

  localparam int unsigned TW   = DETW + FRAC_BITS + 2;
  localparam int unsigned DENW = DETW + 2;

  // magnitudes and signs
  logic              v1_q;
  logic [DETW-1:0]   an1_q, ad1_q;
  logic              neg1_q, zero1_q;

  // rounded dividend and divisor
  logic              v2_q;
  logic [TW-1:0]     top_d;
  logic [DENW-1:0]   den_d;
  logic [TW-1:0]     rem_s [QW+1];
  logic [DENW-1:0]   den_s [QW+1];
  logic [QW-1:0]     quo_s [QW+1];
  tcc_flags_t        flg_s [QW+1];
  logic              val_s [QW+1];

  // result
  logic              v3_q;
  logic [QW-1:0]     lim, val_d, val_q;
  logic              sat_d, sat_q, zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= val_s[QW];
    end
  end

  always_comb begin
    top_d = (TW'(an1_q) << (FRAC_BITS + 1)) + (TW'(ad1_q) << 1);
    den_d = DENW'(ad1_q) << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= num_i[DETW-1] ^ d0_i[DETW-1];
      zero1_q <= (d0_i == '0);
      an1_q   <= num_i[DETW-1] ? DETW'(-num_i) : DETW'(num_i);
      ad1_q   <= d0_i[DETW-1] ? DETW'(-d0_i) : DETW'(d0_i);
      rem_s[0]      <= top_d;
      den_s[0]      <= den_d;
      quo_s[0]      <= '0;
      flg_s[0].neg  <= neg1_q;
      flg_s[0].zero <= zero1_q;
      flg_s[0].over <= (top_d >> QW) >= TW'(den_d);
    end
  end

  assign val_s[0] = v2_q;

  for (genvar g = 0; g < QW; g++) begin : g_step
    tcc_div_step #(
      .TW   (TW),
      .DENW (DENW),
      .SHIFT(QW - 1 - g)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(val_s[g]),
      .rem_i  (rem_s[g]),
      .den_i  (den_s[g]),
      .quo_i  (quo_s[g]),
      .flags_i(flg_s[g]),
      .valid_o(val_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .den_o  (den_s[g+1]),
      .quo_o  (quo_s[g+1]),
      .flags_o(flg_s[g+1])
    );
  end

  always_comb begin
    lim   = flg_s[QW].neg ? NEG_LIMIT : POS_LIMIT;
    sat_d = flg_s[QW].over || (quo_s[QW] > lim);
    if (sat_d) begin
      val_d = lim;
    end else if (flg_s[QW].neg) begin
      val_d = QW'(-quo_s[QW]);
    end else begin
      val_d = quo_s[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= val_d;
      sat_q  <= sat_d;
      zero_q <= flg_s[QW].zero;
    end
  end

  assign valid_o = v3_q;
  assign value_o = val_q;
  assign sat_o   = sat_q;
  assign zero_o  = zero_q;

endmodule

FILE: design/tcc_det.sv
// exact determinant pipeline: plain determinant and three numerators
// depends on tcc_pkg
module tcc_det #(
  parameter int unsigned COORD_BITS = tcc_pkg::COORD_BITS_DEF,
  localparam int unsigned DETW      = 4*COORD_BITS + 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  tcc_pkg::tcc_in_t       data_i,
  output logic                   valid_o,
  output logic signed [DETW-1:0] d0_o,
  output logic signed [DETW-1:0] num_x_o,
  output logic signed [DETW-1:0] num_y_o,
  output logic signed [DETW-1:0] num_z_o
);
  import tcc_pkg::*;

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned AW  = CW + 1;
  localparam int unsigned SW  = 2*CW;
  localparam int unsigned NW  = 2*CW + 1;
  localparam int unsigned MW  = 2*CW + 2;
  localparam int unsigned PNW = 3*CW + 2;
  localparam int unsigned NNW = 3*CW + 3;
  localparam int unsigned DPW = 3*CW + 3;
  localparam int unsigned DMW = 4*CW + 3;
  localparam int unsigned PRW = 4*CW + 4;

  logic signed [IN_W-1:0] raw [4][3];
  logic signed [CW-1:0]   c   [4][3];

  logic                   v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic signed [AW-1:0]   a1_q [3][3];
  logic signed [SW-1:0]   sq1_q [4][3];
  logic signed [AW-1:0]   a2_q [3][3];
  logic signed [NW-1:0]   dn2_q [3];
  logic signed [MW-1:0]   pm2_q [3][2];
  logic signed [AW-1:0]   a3_q [3];
  logic signed [NW-1:0]   dn3_q;
  logic signed [MW-1:0]   m3_q [3];
  logic signed [PNW-1:0]  pn3_q [3][2];
  logic signed [AW-1:0]   a4_q [3];
  logic signed [NNW-1:0]  nn4_q [3];
  logic signed [DMW-1:0]  dm4_q [3];
  logic signed [DPW-1:0]  dp4_q [3];
  logic signed [DMW-1:0]  dm5_q [3];
  logic signed [PRW-1:0]  pyz5_q, pzy5_q, pxz5_q, pzx5_q, pxy5_q, pyx5_q;
  logic signed [DETW-1:0] d05_q;
  logic signed [DETW-1:0] d06_q, nx6_q, ny6_q, nz6_q;

  logic [SW-1:0]          n2 [4];

  always_comb begin
    logic signed [31:0] ext;
    raw[0][0] = data_i.p0_x; raw[0][1] = data_i.p0_y; raw[0][2] = data_i.p0_z;
    raw[1][0] = data_i.p1_x; raw[1][1] = data_i.p1_y; raw[1][2] = data_i.p1_z;
    raw[2][0] = data_i.p2_x; raw[2][1] = data_i.p2_y; raw[2][2] = data_i.p2_z;
    raw[3][0] = data_i.p3_x; raw[3][1] = data_i.p3_y; raw[3][2] = data_i.p3_z;
    for (int v = 0; v < 4; v++) begin
      for (int k = 0; k < 3; k++) begin
        ext     = raw[v][k];
        c[v][k] = ext[CW-1:0];
      end
    end
  end

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      n2[v] = SW'($unsigned(sq1_q[v][0])) + SW'($unsigned(sq1_q[v][1]))
            + SW'($unsigned(sq1_q[v][2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // edge vectors and squares
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          a1_q[i][k] <= AW'(c[i+1][k]) - AW'(c[0][k]);
        end
      end
      for (int v = 0; v < 4; v++) begin
        for (int k = 0; k < 3; k++) begin
          sq1_q[v][k] <= SW'(c[v][k]) * SW'(c[v][k]);
        end
      end
      // norm differences and 2x2 products
      a2_q <= a1_q;
      for (int i = 0; i < 3; i++) begin
        dn2_q[i] <= $signed({1'b0, n2[i+1]}) - $signed({1'b0, n2[0]});
      end
      for (int k = 0; k < 3; k++) begin
        pm2_q[k][0] <= MW'(a1_q[1][(k == 0) ? 1 : 0]) * MW'(a1_q[2][(k == 2) ? 1 : 2]);
        pm2_q[k][1] <= MW'(a1_q[1][(k == 2) ? 1 : 2]) * MW'(a1_q[2][(k == 0) ? 1 : 0]);
      end
      // 2x2 minors and norm products
      a3_q  <= a2_q[0];
      dn3_q <= dn2_q[0];
      for (int k = 0; k < 3; k++) begin
        m3_q[k]     <= pm2_q[k][0] - pm2_q[k][1];
        pn3_q[k][0] <= PNW'(dn2_q[1]) * PNW'(a2_q[2][k]);
        pn3_q[k][1] <= PNW'(a2_q[1][k]) * PNW'(dn2_q[2]);
      end
      // norm minors and first row products
      a4_q <= a3_q;
      for (int k = 0; k < 3; k++) begin
        nn4_q[k] <= NNW'(pn3_q[k][0]) - NNW'(pn3_q[k][1]);
        dm4_q[k] <= DMW'(dn3_q) * DMW'(m3_q[k]);
        dp4_q[k] <= DPW'(a3_q[k]) * DPW'(m3_q[k]);
      end
      // products with norm minors, plain determinant
      dm5_q  <= dm4_q;
      pyz5_q <= PRW'(a4_q[1]) * PRW'(nn4_q[2]);
      pzy5_q <= PRW'(a4_q[2]) * PRW'(nn4_q[1]);
      pxz5_q <= PRW'(a4_q[0]) * PRW'(nn4_q[2]);
      pzx5_q <= PRW'(a4_q[2]) * PRW'(nn4_q[0]);
      pxy5_q <= PRW'(a4_q[0]) * PRW'(nn4_q[1]);
      pyx5_q <= PRW'(a4_q[1]) * PRW'(nn4_q[0]);
      d05_q  <= DETW'(dp4_q[0]) - DETW'(dp4_q[1]) + DETW'(dp4_q[2]);
      // numerators
      d06_q <= d05_q;
      nx6_q <= DETW'(dm5_q[0]) - DETW'(pyz5_q) + DETW'(pzy5_q);
      ny6_q <= DETW'(pxz5_q) - DETW'(pzx5_q) - DETW'(dm5_q[1]);
      nz6_q <= DETW'(dm5_q[2]) - DETW'(pxy5_q) + DETW'(pyx5_q);
    end
  end

  assign valid_o = v6_q;
  assign d0_o    = d06_q;
  assign num_x_o = nx6_q;
  assign num_y_o = ny6_q;
  assign num_z_o = nz6_q;

endmodule

FILE: design/tetrahedron_circumcenter_top.sv
// Circumcenter of a tetrahedron from four integer vertices. One transaction is
// accepted per clock while not stalled, and its result passes six stages of exact
// determinant arithmetic, two stages of division setup, one stage per quotient bit
// for 32 bits and one rounding and saturation stage. The whole pipeline holds while
// a result waits under stall, so in_stall_o follows out_stall_i whenever a result
// is presented. Coplanar inputs give a zero center with degenerate set.
// depends on tcc_pkg, tcc_det, tcc_quot
module tetrahedron_circumcenter_top #(
  parameter int unsigned COORD_BITS = tcc_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcc_pkg::tcc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcc_pkg::tcc_out_t out_data_o
);
  import tcc_pkg::*;

  localparam int unsigned DETW = 4*COORD_BITS + 4;

  logic                   en;
  logic                   det_valid;
  logic signed [DETW-1:0] d0, num_x, num_y, num_z;
  logic                   vx, vy, vz;
  logic [QW-1:0]          qx, qy, qz;
  logic                   sx, sy, sz;
  logic                   zx, zy, zz;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  tcc_det #(.COORD_BITS(COORD_BITS)) u_det (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .valid_o(det_valid),
    .d0_o   (d0),
    .num_x_o(num_x),
    .num_y_o(num_y),
    .num_z_o(num_z)
  );

  tcc_quot #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_quot_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(det_valid),
    .num_i(num_x), .d0_i(d0),
    .valid_o(vx), .value_o(qx), .sat_o(sx), .zero_o(zx)
  );

  tcc_quot #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_quot_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(det_valid),
    .num_i(num_y), .d0_i(d0),
    .valid_o(vy), .value_o(qy), .sat_o(sy), .zero_o(zy)
  );

  tcc_quot #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_quot_z (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(det_valid),
    .num_i(num_z), .d0_i(d0),
    .valid_o(vz), .value_o(qz), .sat_o(sz), .zero_o(zz)
  );

  always_comb begin
    out_valid_o           = vx;
    out_data_o.degenerate = zx;
    out_data_o.saturated  = !zx && (sx || sy || sz);
    out_data_o.center_x   = zx ? '0 : $signed(qx);
    out_data_o.center_y   = zx ? '0 : $signed(qy);
    out_data_o.center_z   = zx ? '0 : $signed(qz);
  end

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vx == vy) && (vy == vz) && (!vx || ((zx == zy) && (zy == zz))))
    else $error("quotient lanes out of step");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.degenerate && out_data_o.saturated))
    else $error("degenerate and saturated together");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.center_x == '0) && (out_data_o.center_y == '0) &&
      (out_data_o.center_z == '0))
    else $error("degenerate result with nonzero center");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      (qx == POS_LIMIT) || (qx == NEG_LIMIT) || (qy == POS_LIMIT) ||
      (qy == NEG_LIMIT) || (qz == POS_LIMIT) || (qz == NEG_LIMIT))
    else $error("saturated without a clipped coordinate");

endmodule

FILE: test/tb_tetrahedron_circumcenter_top.sv
// testbench for tetrahedron_circumcenter_top: random and directed tetrahedra, results
// checked in order against an exact wide-integer circumcenter predictor
// depends on tcc_pkg and the design files
`timescale 1ns / 100ps

module tb_tetrahedron_circumcenter_top;
  import tcc_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int NUM_RANDOM = 1500;
  localparam int WD_LIMIT   = 20000;
  localparam int LATENCY    = 41;

  typedef logic signed [255:0] wide_t;

  class center_scoreboard;
    tcc_out_t pending[$];
    int       mismatches;
    int       checked;

    function void note_input(tcc_out_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(tcc_out_t act);
      tcc_out_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", act);
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (act !== exp_res) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch #%0d exp %p act %p", checked, exp_res, act);
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tcc_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tcc_out_t out_data_o;

  center_scoreboard sb;
  int  idle_cycles = 0;
  bit  hold_long;

  tetrahedron_circumcenter_top #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  function automatic wide_t det3(wide_t a0, wide_t a1, wide_t a2, wide_t b0, wide_t b1,
                                 wide_t b2, wide_t c0, wide_t c1, wide_t c2);
    return a0 * (b1 * c2 - b2 * c1) - a1 * (b0 * c2 - b2 * c0) + a2 * (b0 * c1 - b1 * c0);
  endfunction

  // 4x4 determinant with first column all ones, rows as (1, a, b, c)
  function automatic wide_t det4(wide_t a[4], wide_t b[4], wide_t c[4]);
    return det3(a[1], b[1], c[1], a[2], b[2], c[2], a[3], b[3], c[3])
         - det3(a[0], b[0], c[0], a[2], b[2], c[2], a[3], b[3], c[3])
         + det3(a[0], b[0], c[0], a[1], b[1], c[1], a[3], b[3], c[3])
         - det3(a[0], b[0], c[0], a[1], b[1], c[1], a[2], b[2], c[2]);
  endfunction

  function automatic logic [QW-1:0] rounded_quotient(wide_t num, wide_t d0, ref bit sat);
    bit    neg;
    wide_t an, ad, q;
    neg = (num < 0) != (d0 < 0);
    an  = num < 0 ? -num : num;
    ad  = d0 < 0 ? -d0 : d0;
    q   = ((an <<< (FRAC_BITS + 1)) + (ad <<< 1)) / (ad <<< 2);
    if (q > (neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff))) begin
      sat = 1'b1;
      return neg ? NEG_LIMIT : POS_LIMIT;
    end
    return neg ? QW'(-q) : QW'(q);
  endfunction

  function automatic tcc_out_t circumcenter(tcc_in_t t);
    logic signed [IN_W-1:0] c[12];
    wide_t    xs[4], ys[4], zs[4], ns[4];
    wide_t    d0;
    bit       sat;
    tcc_out_t r;
    c = '{t.p0_x, t.p0_y, t.p0_z, t.p1_x, t.p1_y, t.p1_z,
          t.p2_x, t.p2_y, t.p2_z, t.p3_x, t.p3_y, t.p3_z};
    sat = 1'b0;
    for (int v = 0; v < 4; v++) begin
      xs[v] = c[v*3];
      ys[v] = c[v*3+1];
      zs[v] = c[v*3+2];
      ns[v] = xs[v] * xs[v] + ys[v] * ys[v] + zs[v] * zs[v];
    end
    r  = '0;
    d0 = det4(xs, ys, zs);
    if (d0 == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.center_x  = rounded_quotient(det4(ns, ys, zs), d0, sat);
    r.center_y  = rounded_quotient(-det4(ns, xs, zs), d0, sat);
    r.center_z  = rounded_quotient(det4(ns, xs, ys), d0, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic tcc_in_t pack_coords(int v[12]);
    tcc_in_t t;
    t = {v[0][15:0], v[1][15:0], v[2][15:0], v[3][15:0], v[4][15:0], v[5][15:0],
         v[6][15:0], v[7][15:0], v[8][15:0], v[9][15:0], v[10][15:0], v[11][15:0]};
    return t;
  endfunction

  task automatic send_tetra(tcc_in_t t);
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(circumcenter(t));
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 40) - 20;
      2: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) : -32768 + $urandom_range(0, 3);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  task automatic run_directed();
    int v[12];
    // unit tetrahedron, regular shapes, extremes, coplanar, ties
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};  send_tetra(pack_coords(v));
    v = '{0, 0, 0, 2, 0, 0, 0, 2, 0, 0, 0, 2};  send_tetra(pack_coords(v));
    v = '{1, 1, 1, 1, -1, -1, -1, 1, -1, -1, -1, 1}; send_tetra(pack_coords(v));
    v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
          -32768, -32768, 32767}; send_tetra(pack_coords(v));
    v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767,
          32767, 32767, -32768}; send_tetra(pack_coords(v));
    v = '{0, 0, 0, 1, 0, 0, 2, 0, 0, 3, 0, 0};  send_tetra(pack_coords(v));
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0};  send_tetra(pack_coords(v));
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};  send_tetra(pack_coords(v));
    v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
          -32768, -32768, -32768}; send_tetra(pack_coords(v));
    // nearly flat sliver drives saturation
    v = '{-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0, 0, 0, 1};
    send_tetra(pack_coords(v));
    v = '{-32768, 32767, 0, 32767, 32767, 0, 0, -32768, 0, 1, 1, -1};
    send_tetra(pack_coords(v));
    v = '{0, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, -32768};
    send_tetra(pack_coords(v));
    v = '{-1, 0, 0, 0, -1, 0, 0, 0, -1, -1, -1, -1}; send_tetra(pack_coords(v));
    v = '{0, 0, 0, 3, 0, 0, 0, 1, 0, 0, 0, 1}; send_tetra(pack_coords(v));
    v = '{5, 5, 5, 5, 5, 5, 1, 2, 3, 4, 5, 6}; send_tetra(pack_coords(v));
    in_valid_i <= 1'b0;
  endtask

  task automatic run_random();
    int      v[12];
    int      mode;
    tcc_in_t t;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 12; k++) v[k] = rand_coord(mode);
      t = pack_coords(v);
      if ($urandom_range(0, 15) == 0) begin
        t.p3_x = t.p2_x;
        t.p3_y = t.p2_y;
        t.p3_z = t.p2_z;
      end
      if (i == 300) hold_long = 1'b1;
      send_tetra(t);
      sender_gap();
    end
    in_valid_i <= 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    int phase;
    out_stall_i = 1'b0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        hold_long = 1'b0;
      end
      phase = (phase + 1) % 97;
      out_stall_i <= (phase > 60) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_tetrahedron_circumcenter_top: done, errors");
      $finish;
    end
  end

  initial begin
    sb          = new();
    hold_long   = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.mismatches == 0) $display("tb_tetrahedron_circumcenter_top: done, clean");
    else $display("tb_tetrahedron_circumcenter_top: done, errors");
    $finish;
  end

endmodule

FILE: tetrahedron_circumcenter_top.f
design/tcc_pkg.sv
design/tcc_div_step.sv
design/tcc_quot.sv
design/tcc_det.sv
design/tetrahedron_circumcenter_top.sv
test/tb_tetrahedron_circumcenter_top.sv
